// ===== rtl/chip8_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, opcode codes, font table and controller/datapath types.
package chip8_pkg;

   localparam int MEM_BYTES       = 4096;
   localparam int ADDR_W          = 12;
   localparam int SCREEN_COLS     = 64;
   localparam int SCREEN_ROWS     = 32;
   localparam int ROW_W           = 5;
   localparam int COL_W           = 6;
   localparam int NUM_VREGS       = 16;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int FONT_BYTES      = 80;

   localparam logic [11:0] START_PC   = 12'h200;
   localparam logic [15:0] SEED_RESET = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS  = 16'hB400;
   localparam logic [3:0]  VF_INDEX   = 4'hF;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EXEC  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam int          CSR_ADDR_W = 3;
   localparam logic [2:0]  CSR_SEED   = 3'd0;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] G_SYS      = 4'h0;
   localparam logic [3:0] G_JUMP     = 4'h1;
   localparam logic [3:0] G_CALL     = 4'h2;
   localparam logic [3:0] G_SKIP_EQ  = 4'h3;
   localparam logic [3:0] G_SKIP_NE  = 4'h4;
   localparam logic [3:0] G_SKIP_REQ = 4'h5;
   localparam logic [3:0] G_LOAD     = 4'h6;
   localparam logic [3:0] G_ADD      = 4'h7;
   localparam logic [3:0] G_ALU      = 4'h8;
   localparam logic [3:0] G_SKIP_RNE = 4'h9;
   localparam logic [3:0] G_INDEX    = 4'hA;
   localparam logic [3:0] G_JUMP_V0  = 4'hB;
   localparam logic [3:0] G_RAND     = 4'hC;
   localparam logic [3:0] G_DRAW     = 4'hD;
   localparam logic [3:0] G_KEY      = 4'hE;
   localparam logic [3:0] G_MISC     = 4'hF;

   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   localparam logic [7:0] F_DELAY_RD = 8'h07;
   localparam logic [7:0] F_KEY_WAIT = 8'h0A;
   localparam logic [7:0] F_DELAY_WR = 8'h15;
   localparam logic [7:0] F_SOUND_WR = 8'h18;
   localparam logic [7:0] F_INDEX_AD = 8'h1E;
   localparam logic [7:0] F_FONT     = 8'h29;
   localparam logic [7:0] F_BCD      = 8'h33;
   localparam logic [7:0] F_STORE    = 8'h55;
   localparam logic [7:0] F_LOAD     = 8'h65;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_ACCEPT, DP_MEM_WRITE, DP_ROW_READ, DP_ROW_LATCH,
      DP_FETCH_HI, DP_FETCH_LO, DP_READ_X, DP_READ_Y, DP_READ_0, DP_DECODE,
      DP_EXEC, DP_WRITE_VF, DP_CLS_ROW, DP_DRAW_READ, DP_DRAW_WRITE, DP_DRAW_END,
      DP_BCD, DP_STORE_READ, DP_STORE_WRITE, DP_LOAD_READ, DP_LOAD_WRITE,
      DP_INDEX_ADV, DP_FINISH, DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic [11:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic [1:0]  action;
      logic        rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/chip8_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the CHIP-8 core.
interface chip8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [11:0] address;
   logic [7:0]  data;
   logic [15:0] keys;
   logic [4:0]  row;

   modport source (output valid, action, address, data, keys, row, input ready);
   modport sink (input valid, action, address, data, keys, row, output ready);
endinterface

interface chip8_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] row_pixels;
   logic [11:0] program_counter;
   logic        draw_flag;
   logic        sound_on;
   logic        bad_opcode;
   logic        waiting_key;

   modport source (output valid, row_pixels, program_counter, draw_flag, sound_on,
                   bad_opcode, waiting_key, input ready);
   modport sink (input valid, row_pixels, program_counter, draw_flag, sound_on,
                 bad_opcode, waiting_key, output ready);
endinterface

// ===== rtl/chip8_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps the datapath through fetch, decode and multi-cycle operations.
module chip8_ctrl import chip8_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output logic          req_ready,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_MEM_WRITE, ST_ROW_READ, ST_ROW_LATCH,
      ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y, ST_READ_0, ST_DECODE,
      ST_EXEC, ST_WRITE_VF, ST_CLS, ST_DRAW_READ, ST_DRAW_WRITE, ST_DRAW_END,
      ST_BCD, ST_STORE_READ, ST_STORE_WRITE, ST_LOAD_READ, ST_LOAD_WRITE,
      ST_INDEX_ADV, ST_FINISH, ST_RESPOND
   } state_type;

   state_type   state_ff;
   logic [11:0] cnt_ff;

   logic [3:0] grp, op_x, op_n;
   logic [7:0] op_nn;
   logic       needs_vf;

   assign grp   = status.opcode[15:12];
   assign op_x  = status.opcode[11:8];
   assign op_n  = status.opcode[3:0];
   assign op_nn = status.opcode[7:0];

   assign needs_vf = (grp == G_ALU && (op_n == ALU_ADD || op_n == ALU_SUB ||
                      op_n == ALU_SHR || op_n == ALU_SUBN || op_n == ALU_SHL)) ||
                     (grp == G_MISC && op_nn == F_INDEX_AD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff == 12'(MEM_BYTES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_DISPATCH;
            end
            ST_DISPATCH: begin
               cnt_ff <= '0;
               unique case (status.action)
                  ACT_WRITE: state_ff <= ST_MEM_WRITE;
                  ACT_EXEC:  state_ff <= ST_FETCH_HI;
                  ACT_READ:  state_ff <= ST_ROW_READ;
                  default:   state_ff <= ST_RESPOND;
               endcase
            end
            ST_MEM_WRITE: state_ff <= ST_RESPOND;
            ST_ROW_READ:  state_ff <= ST_ROW_LATCH;
            ST_ROW_LATCH: state_ff <= ST_RESPOND;
            ST_FETCH_HI:  state_ff <= ST_FETCH_LO;
            ST_FETCH_LO:  state_ff <= ST_READ_X;
            ST_READ_X:    state_ff <= ST_READ_Y;
            ST_READ_Y:    state_ff <= ST_READ_0;
            ST_READ_0:    state_ff <= ST_DECODE;
            ST_DECODE: begin
               priority if (status.opcode == OP_CLS) state_ff <= ST_CLS;
               else if (grp == G_DRAW) state_ff <= (op_n == 4'd0) ? ST_DRAW_END : ST_DRAW_READ;
               else if (grp == G_MISC && op_nn == F_BCD) state_ff <= ST_BCD;
               else if (grp == G_MISC && op_nn == F_STORE) state_ff <= ST_STORE_READ;
               else if (grp == G_MISC && op_nn == F_LOAD) state_ff <= ST_LOAD_READ;
               else state_ff <= ST_EXEC;
            end
            ST_EXEC:      state_ff <= needs_vf ? ST_WRITE_VF : ST_RESPOND;
            ST_WRITE_VF:  state_ff <= ST_RESPOND;
            ST_CLS: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff == 12'(SCREEN_ROWS - 1)) state_ff <= ST_FINISH;
            end
            ST_DRAW_READ: state_ff <= ST_DRAW_WRITE;
            ST_DRAW_WRITE: begin
               cnt_ff <= cnt_ff + 12'd1;
               state_ff <= (cnt_ff[3:0] == op_n - 4'd1) ? ST_DRAW_END : ST_DRAW_READ;
            end
            ST_DRAW_END:  state_ff <= ST_FINISH;
            ST_BCD: begin
               cnt_ff <= cnt_ff + 12'd1;
               if (cnt_ff == 12'd2) state_ff <= ST_FINISH;
            end
            ST_STORE_READ: state_ff <= ST_STORE_WRITE;
            ST_STORE_WRITE: begin
               cnt_ff <= cnt_ff + 12'd1;
               state_ff <= (cnt_ff[3:0] == op_x) ? ST_INDEX_ADV : ST_STORE_READ;
            end
            ST_LOAD_READ: state_ff <= ST_LOAD_WRITE;
            ST_LOAD_WRITE: begin
               cnt_ff <= cnt_ff + 12'd1;
               state_ff <= (cnt_ff[3:0] == op_x) ? ST_INDEX_ADV : ST_LOAD_READ;
            end
            ST_INDEX_ADV: state_ff <= ST_FINISH;
            ST_FINISH:    state_ff <= ST_RESPOND;
            ST_RESPOND: begin
               if (status.rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.cnt   = cnt_ff;

   always_comb begin
      unique case (state_ff)
         ST_CLEAR:       cmd.op = DP_CLEAR;
         ST_IDLE:        cmd.op = DP_ACCEPT;
         ST_MEM_WRITE:   cmd.op = DP_MEM_WRITE;
         ST_ROW_READ:    cmd.op = DP_ROW_READ;
         ST_ROW_LATCH:   cmd.op = DP_ROW_LATCH;
         ST_FETCH_HI:    cmd.op = DP_FETCH_HI;
         ST_FETCH_LO:    cmd.op = DP_FETCH_LO;
         ST_READ_X:      cmd.op = DP_READ_X;
         ST_READ_Y:      cmd.op = DP_READ_Y;
         ST_READ_0:      cmd.op = DP_READ_0;
         ST_DECODE:      cmd.op = DP_DECODE;
         ST_EXEC:        cmd.op = DP_EXEC;
         ST_WRITE_VF:    cmd.op = DP_WRITE_VF;
         ST_CLS:         cmd.op = DP_CLS_ROW;
         ST_DRAW_READ:   cmd.op = DP_DRAW_READ;
         ST_DRAW_WRITE:  cmd.op = DP_DRAW_WRITE;
         ST_DRAW_END:    cmd.op = DP_DRAW_END;
         ST_BCD:         cmd.op = DP_BCD;
         ST_STORE_READ:  cmd.op = DP_STORE_READ;
         ST_STORE_WRITE: cmd.op = DP_STORE_WRITE;
         ST_LOAD_READ:   cmd.op = DP_LOAD_READ;
         ST_LOAD_WRITE:  cmd.op = DP_LOAD_WRITE;
         ST_INDEX_ADV:   cmd.op = DP_INDEX_ADV;
         ST_FINISH:      cmd.op = DP_FINISH;
         ST_RESPOND:     cmd.op = status.rsp_free ? DP_RESPOND : DP_NOP;
         default:        cmd.op = DP_NOP;
      endcase
   end

endmodule

// ===== rtl/chip8_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: memories, register file, stack, timers, LFSR and response register.
module chip8_dpath import chip8_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_action,
   input  logic [11:0]   req_address,
   input  logic [7:0]    req_data,
   input  logic [15:0]   req_keys,
   input  logic [4:0]    req_row,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_row_pixels,
   output logic [11:0]   rsp_program_counter,
   output logic          rsp_draw_flag,
   output logic          rsp_sound_on,
   output logic          rsp_bad_opcode,
   output logic          rsp_waiting_key,
   input  logic          csr_write,
   input  logic [15:0]   csr_wdata,
   output logic [15:0]   csr_seed
);

   localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // storage
   logic [7:0]        mem_ff   [MEM_BYTES];
   logic [63:0]       frame_ff [SCREEN_ROWS];
   logic [7:0]        regs_ff  [NUM_VREGS];
   logic [11:0]       stack_ff [STACK_DEPTH];
   logic [NUM_VREGS-1:0]   reg_valid_ff;
   logic [STACK_DEPTH-1:0] stk_valid_ff;

   logic [7:0]  mem_rd_ff;
   logic [63:0] fr_rd_ff;
   logic [7:0]  rf_rd_ff;
   logic [11:0] stk_rd_ff;

   // request and operand registers
   logic [1:0]  action_ff;
   logic [11:0] address_ff;
   logic [7:0]  data_ff;
   logic [15:0] keys_ff;
   logic [4:0]  row_ff;
   logic [15:0] op_ff;
   logic [7:0]  vx_ff, vy_ff, v0_ff, vf_val_ff;
   logic        collision_ff;
   logic [63:0] pixels_ff;

   // architectural state
   logic [11:0]     pc_ff, index_ff;
   logic [SP_W-1:0] sp_ff;
   logic [7:0]      delay_ff, sound_ff;
   logic            changed_ff, bad_ff, wait_ff;
   logic [15:0]     lfsr_ff, seed_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_pixels_ff;
   logic [11:0] rsp_pc_ff;
   logic        rsp_draw_ff, rsp_sound_ff, rsp_bad_ff, rsp_wait_ff;

   // memory ports
   logic            mem_we;
   logic [11:0]     mem_waddr, mem_raddr;
   logic [7:0]      mem_wdata;
   logic            fr_we;
   logic [4:0]      fr_waddr, fr_raddr;
   logic [63:0]     fr_wdata;
   logic            rf_we;
   logic [3:0]      rf_waddr, rf_raddr;
   logic [7:0]      rf_wdata;
   logic            stk_we;
   logic [SP_W-1:0] sp_inc, sp_dec;

   // decode and execute
   logic [3:0]  grp, op_x, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn;
   logic [11:0] exec_pc, exec_index;
   logic [7:0]  exec_vx, exec_vf, exec_delay, exec_sound;
   logic        exec_wr, exec_bad, exec_wait, exec_call, exec_ret, exec_rand;
   logic [15:0] lfsr_next;
   logic [8:0]  sum9, diff_xy, diff_yx;
   logic [12:0] index_sum;
   logic        pressed;
   logic [3:0]  high_key;
   logic [11:0] cnt_addr;
   logic [4:0]  draw_line;
   logic [63:0] sprite_mask;
   logic [127:0] sprite_pair;
   logic [1:0]  hund;
   logic [7:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens, ones;
   logic [6:0]  tens_x10;
   logic [7:0]  bcd_digit;

   assign grp    = op_ff[15:12];
   assign op_x   = op_ff[11:8];
   assign op_n   = op_ff[3:0];
   assign op_nn  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];

   assign sp_inc = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + SP_W'(1);
   assign sp_dec = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - SP_W'(1);

   assign cnt_addr    = index_ff + cmd.cnt;
   assign draw_line   = vy_ff[4:0] + cmd.cnt[4:0];
   assign sprite_pair = {mem_rd_ff, 56'd0, mem_rd_ff, 56'd0} >> vx_ff[COL_W-1:0];
   assign sprite_mask = sprite_pair[63:0];

   assign lfsr_next = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
   assign sum9      = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign diff_xy   = {1'b0, vx_ff} - {1'b0, vy_ff};
   assign diff_yx   = {1'b0, vy_ff} - {1'b0, vx_ff};
   assign index_sum = {1'b0, index_ff} + {5'd0, vx_ff};
   assign pressed   = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];

   always_comb begin
      high_key = '0;
      for (int i = 0; i < 16; i++) begin
         if (keys_ff[i]) high_key = 4'(i);
      end
   end

   // decimal digits
   always_comb begin
      if (vx_ff >= 8'd200) hund = 2'd2;
      else if (vx_ff >= 8'd100) hund = 2'd1;
      else hund = 2'd0;
      rem       = vx_ff - 8'(hund) * 8'd100;
      tens_prod = 15'(rem[6:0]) * 15'd205;
      tens      = tens_prod[14:11];
      tens_x10  = 7'(tens) * 7'd10;
      ones      = 4'(rem[6:0] - tens_x10);
      unique case (cmd.cnt[1:0])
         2'd0:    bcd_digit = {6'd0, hund};
         2'd1:    bcd_digit = {4'd0, tens};
         default: bcd_digit = {4'd0, ones};
      endcase
   end

   always_comb begin
      exec_pc    = pc_ff + 12'd2;
      exec_index = index_ff;
      exec_vx    = vx_ff;
      exec_vf    = vf_val_ff;
      exec_delay = delay_ff;
      exec_sound = sound_ff;
      exec_wr    = 1'b0;
      exec_bad   = 1'b0;
      exec_wait  = 1'b0;
      exec_call  = 1'b0;
      exec_ret   = 1'b0;
      exec_rand  = 1'b0;
      unique case (grp)
         G_SYS: begin
            if (op_ff == OP_RET) begin
               exec_ret = 1'b1;
               exec_pc  = stk_rd_ff + 12'd2;
            end else begin
               exec_bad = 1'b1;
            end
         end
         G_JUMP: exec_pc = op_nnn;
         G_CALL: begin
            exec_call = 1'b1;
            exec_pc   = op_nnn;
         end
         G_SKIP_EQ: if (vx_ff == op_nn) exec_pc = pc_ff + 12'd4;
         G_SKIP_NE: if (vx_ff != op_nn) exec_pc = pc_ff + 12'd4;
         G_SKIP_REQ: begin
            if (op_n != 4'd0) exec_bad = 1'b1;
            else if (vx_ff == vy_ff) exec_pc = pc_ff + 12'd4;
         end
         G_LOAD: begin
            exec_vx = op_nn;
            exec_wr = 1'b1;
         end
         G_ADD: begin
            exec_vx = vx_ff + op_nn;
            exec_wr = 1'b1;
         end
         G_ALU: begin
            exec_wr = 1'b1;
            unique case (op_n)
               ALU_MOV: exec_vx = vy_ff;
               ALU_OR:  exec_vx = vx_ff | vy_ff;
               ALU_AND: exec_vx = vx_ff & vy_ff;
               ALU_XOR: exec_vx = vx_ff ^ vy_ff;
               ALU_ADD: begin
                  exec_vx = sum9[7:0];
                  exec_vf = {7'd0, sum9[8]};
               end
               ALU_SUB: begin
                  exec_vx = diff_xy[7:0];
                  exec_vf = {7'd0, !diff_xy[8]};
               end
               ALU_SHR: begin
                  exec_vx = {1'b0, vx_ff[7:1]};
                  exec_vf = {7'd0, vx_ff[0]};
               end
               ALU_SUBN: begin
                  exec_vx = diff_yx[7:0];
                  exec_vf = {7'd0, !diff_yx[8]};
               end
               ALU_SHL: begin
                  exec_vx = {vx_ff[6:0], 1'b0};
                  exec_vf = {7'd0, vx_ff[7]};
               end
               default: begin
                  exec_wr  = 1'b0;
                  exec_bad = 1'b1;
               end
            endcase
         end
         G_SKIP_RNE: begin
            if (op_n != 4'd0) exec_bad = 1'b1;
            else if (vx_ff != vy_ff) exec_pc = pc_ff + 12'd4;
         end
         G_INDEX:   exec_index = op_nnn;
         G_JUMP_V0: exec_pc = op_nnn + {4'd0, v0_ff};
         G_RAND: begin
            exec_rand = 1'b1;
            exec_vx   = lfsr_next[7:0] & op_nn;
            exec_wr   = 1'b1;
         end
         G_KEY: begin
            if (op_nn == KEY_DOWN) begin
               if (pressed) exec_pc = pc_ff + 12'd4;
            end else if (op_nn == KEY_UP) begin
               if (!pressed) exec_pc = pc_ff + 12'd4;
            end else begin
               exec_bad = 1'b1;
            end
         end
         G_MISC: begin
            unique case (op_nn)
               F_DELAY_RD: begin
                  exec_vx = delay_ff;
                  exec_wr = 1'b1;
               end
               F_KEY_WAIT: begin
                  if (keys_ff == 16'd0) begin
                     exec_wait = 1'b1;
                     exec_pc   = pc_ff;
                  end else begin
                     exec_vx = {4'd0, high_key};
                     exec_wr = 1'b1;
                  end
               end
               F_DELAY_WR: exec_delay = vx_ff;
               F_SOUND_WR: exec_sound = vx_ff;
               F_INDEX_AD: begin
                  exec_index = index_sum[11:0];
                  exec_vf    = {7'd0, index_sum[12]};
               end
               F_FONT: exec_index = {6'd0, vx_ff[3:0], 2'd0} + {8'd0, vx_ff[3:0]};
               default: exec_bad = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   // port selection for the memories
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = address_ff;
      mem_wdata = data_ff;
      mem_raddr = pc_ff;
      fr_we     = 1'b0;
      fr_waddr  = cmd.cnt[4:0];
      fr_wdata  = '0;
      fr_raddr  = row_ff;
      rf_we     = 1'b0;
      rf_waddr  = op_x;
      rf_wdata  = exec_vx;
      rf_raddr  = op_x;
      stk_we    = 1'b0;
      unique case (cmd.op)
         DP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cmd.cnt;
            mem_wdata = (cmd.cnt < 12'(FONT_BYTES)) ? FONT_ROM[cmd.cnt[6:0]] : 8'd0;
            fr_we     = (cmd.cnt < 12'(SCREEN_ROWS));
         end
         DP_MEM_WRITE: mem_we = 1'b1;
         DP_FETCH_LO:  mem_raddr = pc_ff + 12'd1;
         DP_READ_Y:    rf_raddr = op_ff[7:4];
         DP_READ_0:    rf_raddr = 4'd0;
         DP_EXEC: begin
            rf_we  = exec_wr;
            stk_we = exec_call;
         end
         DP_WRITE_VF: begin
            rf_we    = 1'b1;
            rf_waddr = VF_INDEX;
            rf_wdata = vf_val_ff;
         end
         DP_CLS_ROW: fr_we = 1'b1;
         DP_DRAW_READ: begin
            mem_raddr = cnt_addr;
            fr_raddr  = draw_line;
         end
         DP_DRAW_WRITE: begin
            fr_we    = 1'b1;
            fr_waddr = draw_line;
            fr_wdata = fr_rd_ff ^ sprite_mask;
         end
         DP_DRAW_END: begin
            rf_we    = 1'b1;
            rf_waddr = VF_INDEX;
            rf_wdata = {7'd0, collision_ff};
         end
         DP_BCD: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_addr;
            mem_wdata = bcd_digit;
         end
         DP_STORE_READ: rf_raddr = cmd.cnt[3:0];
         DP_STORE_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_addr;
            mem_wdata = rf_rd_ff;
         end
         DP_LOAD_READ: mem_raddr = cnt_addr;
         DP_LOAD_WRITE: begin
            rf_we    = 1'b1;
            rf_waddr = cmd.cnt[3:0];
            rf_wdata = mem_rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      mem_rd_ff <= mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (fr_we) frame_ff[fr_waddr] <= fr_wdata;
      fr_rd_ff <= frame_ff[fr_raddr];
   end

   always_ff @(posedge clock) begin
      if (rf_we) regs_ff[rf_waddr] <= rf_wdata;
      rf_rd_ff <= reg_valid_ff[rf_raddr] ? regs_ff[rf_raddr] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_ff[sp_ff] <= pc_ff;
      stk_rd_ff <= stk_valid_ff[sp_dec] ? stack_ff[sp_dec] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
         stk_valid_ff <= '0;
      end else begin
         if (rf_we) reg_valid_ff[rf_waddr] <= 1'b1;
         if (stk_we) stk_valid_ff[sp_ff] <= 1'b1;
      end
   end

   // architectural and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= START_PC;
         index_ff     <= '0;
         sp_ff        <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
         changed_ff   <= 1'b1;
         bad_ff       <= 1'b0;
         wait_ff      <= 1'b0;
         seed_ff      <= SEED_RESET;
         lfsr_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            seed_ff <= csr_wdata;
            lfsr_ff <= (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
         end
         if (cmd.op == DP_RESPOND) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            DP_ACCEPT: begin
               bad_ff  <= 1'b0;
               wait_ff <= 1'b0;
            end
            DP_ROW_READ: changed_ff <= 1'b0;
            DP_EXEC: begin
               bad_ff   <= exec_bad;
               wait_ff  <= exec_wait;
               pc_ff    <= exec_pc;
               index_ff <= exec_index;
               if (exec_rand) lfsr_ff <= lfsr_next;
               if (exec_call) sp_ff <= sp_inc;
               if (exec_ret) sp_ff <= sp_dec;
               if (!exec_wait) begin
                  delay_ff <= exec_delay - 8'(exec_delay != 8'd0);
                  sound_ff <= exec_sound - 8'(exec_sound != 8'd0);
               end
            end
            DP_CLS_ROW, DP_DRAW_END: changed_ff <= 1'b1;
            DP_INDEX_ADV: index_ff <= index_ff + {8'd0, op_x} + 12'd1;
            DP_FINISH: begin
               pc_ff    <= pc_ff + 12'd2;
               delay_ff <= delay_ff - 8'(delay_ff != 8'd0);
               sound_ff <= sound_ff - 8'(sound_ff != 8'd0);
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_ACCEPT: begin
            action_ff  <= req_action;
            address_ff <= req_address;
            data_ff    <= req_data;
            keys_ff    <= req_keys;
            row_ff     <= req_row;
            pixels_ff  <= '0;
         end
         DP_ROW_LATCH: pixels_ff <= fr_rd_ff;
         DP_FETCH_LO:  op_ff[15:8] <= mem_rd_ff;
         DP_READ_X:    op_ff[7:0] <= mem_rd_ff;
         DP_READ_Y:    vx_ff <= rf_rd_ff;
         DP_READ_0:    vy_ff <= rf_rd_ff;
         DP_DECODE: begin
            v0_ff        <= rf_rd_ff;
            collision_ff <= 1'b0;
         end
         DP_EXEC:       vf_val_ff <= exec_vf;
         DP_DRAW_WRITE: collision_ff <= collision_ff | (|(fr_rd_ff & sprite_mask));
         DP_RESPOND: begin
            rsp_pixels_ff <= pixels_ff;
            rsp_pc_ff     <= pc_ff;
            rsp_draw_ff   <= changed_ff;
            rsp_sound_ff  <= (sound_ff != 8'd0);
            rsp_bad_ff    <= bad_ff;
            rsp_wait_ff   <= wait_ff;
         end
         default: ;
      endcase
   end

   assign status.opcode   = op_ff;
   assign status.action   = action_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_row_pixels      = rsp_pixels_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_draw_flag       = rsp_draw_ff;
   assign rsp_sound_on        = rsp_sound_ff;
   assign rsp_bad_opcode      = rsp_bad_ff;
   assign rsp_waiting_key     = rsp_wait_ff;
   assign csr_seed            = seed_ff;

endmodule

// ===== rtl/chip8_interpreter_core.sv =====
`timescale 1ns / 1ps
// Top level of the CHIP-8 core: controller, datapath and register port.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   req_ch   | valid / ready         | action, address, data, keys, row
//   rsp_ch   | valid / ready         | row_pixels, program_counter, draw_flag, ...
//   apb      | psel, penable, pready | paddr, pwrite, pwdata, prdata (random_seed)
//
// One request at a time: a memory write, row read, instruction, screen clear,
// draw (a read and a write per sprite row) or register block copy (a read and
// a write per register) runs as a sequence of states that the single-port
// memories and register file set. A pass after reset loads the font and clears
// memory and display; req_ch.ready stays low during it. A stalled response holds
// in the output register; the next request is taken once it is loaded.
module chip8_interpreter_core import chip8_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   chip8_req_if.sink             req_ch,
   chip8_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;
   logic [15:0]   csr_seed;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_SEED);
   assign prdata    = (paddr == CSR_SEED) ? {16'd0, csr_seed} : 32'd0;

   chip8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   chip8_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_ch.action),
      .req_address         (req_ch.address),
      .req_data            (req_ch.data),
      .req_keys            (req_ch.keys),
      .req_row             (req_ch.row),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_row_pixels      (rsp_ch.row_pixels),
      .rsp_program_counter (rsp_ch.program_counter),
      .rsp_draw_flag       (rsp_ch.draw_flag),
      .rsp_sound_on        (rsp_ch.sound_on),
      .rsp_bad_opcode      (rsp_ch.bad_opcode),
      .rsp_waiting_key     (rsp_ch.waiting_key),
      .csr_write           (csr_write),
      .csr_wdata           (pwdata[15:0]),
      .csr_seed            (csr_seed)
   );

   a_clear_pass: assert property (@(posedge clock) reset |=> !req_ch.ready)
      else $error("request taken during clearing pass");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("controller stayed idle after a request");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.bad_opcode && rsp_ch.waiting_key))
      else $error("bad opcode and key wait both set");

   a_row_read: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.row_pixels != 64'd0) |-> !rsp_ch.draw_flag)
      else $error("draw flag set on a row read response");

endmodule
